// ===== src/dsf_pkg.sv =====
// Shared constants, codes and the job record for the span fill framebuffer.
package dsf_pkg;

    localparam int ROW_BYTES = 20;
    localparam int LINES     = 168;
    localparam int STORE     = ROW_BYTES * LINES;
    localparam int WIDTH_PX  = ROW_BYTES * 8;
    localparam int AW        = $clog2(STORE);
    localparam int CW        = 10;

    typedef enum logic [1:0] {
        CMD_ROW  = 2'd0,
        CMD_COL  = 2'd1,
        CMD_PIX  = 2'd2,
        CMD_READ = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_MIN_X = 2'd0,
        CFG_MAX_X = 2'd1,
        CFG_MIN_Y = 2'd2,
        CFG_MAX_Y = 2'd3
    } t_cfg;

    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_WRITE,
        JOB_READ
    } t_kind;

    typedef struct packed {
        t_kind         kind;
        logic [AW-1:0] addr;
        logic [CW-1:0] cnt;
        logic          col;
        logic          bitwise;
        logic [7:0]    pat;
        logic [7:0]    m_first;
        logic [7:0]    m_mid;
        logic [7:0]    m_last;
        logic          oor;
    } t_job;

    localparam logic [5:0] COLOUR_MASK = 6'h3f;

endpackage

// ===== src/dsf_front.sv =====
// Front end: clip registers and classification of each request into a job.
module dsf_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [7:0]      i_cfg_data,
    input  logic [1:0]      i_command,
    input  logic [11:0]     i_pos_x,
    input  logic [11:0]     i_pos_y,
    input  logic [11:0]     i_span_end,
    input  logic [7:0]      i_fill_pattern,
    input  logic [11:0]     i_read_address,
    output dsf_pkg::t_job   o_job
);
    import dsf_pkg::*;

    logic [7:0] r_min_x, r_max_x, r_min_y, r_max_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= 8'd0;
            r_max_x <= 8'd160;
            r_min_y <= 8'd0;
            r_max_y <= 8'd168;
        end else if (i_cfg_we) begin
            case (t_cfg'(i_cfg_idx))
                CFG_MIN_X: r_min_x <= i_cfg_data;
                CFG_MAX_X: r_max_x <= i_cfg_data;
                CFG_MIN_Y: r_min_y <= i_cfg_data;
                CFG_MAX_Y: r_max_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    localparam logic signed [12:0] W_S = 13'(WIDTH_PX);
    localparam logic signed [12:0] L_S = 13'(LINES);

    logic signed [12:0] x, y, e, minx, maxx, miny, maxy;
    logic signed [12:0] rb, re, rel, cb, ce, cel;
    logic               box_empty, row_empty, col_empty;
    logic [2:0]         rot;
    logic [15:0]        pat2;
    logic [7:0]         pmask;

    always_comb begin
        x    = {i_pos_x[11], i_pos_x};
        y    = {i_pos_y[11], i_pos_y};
        e    = {i_span_end[11], i_span_end};
        minx = {5'd0, r_min_x};
        maxx = {5'd0, r_max_x};
        miny = {5'd0, r_min_y};
        maxy = {5'd0, r_max_y};
        box_empty = (maxx <= minx) || (maxy <= miny);

        row_empty = box_empty || (y < miny) || (y >= maxy) || (e < minx)
                    || (x >= maxx) || (e < x);
        rb  = (x < minx) ? minx : x;
        re  = (e > maxx - 13'sd1) ? maxx - 13'sd1 : e;
        rel = (re >= W_S) ? W_S - 13'sd1 : re;

        col_empty = box_empty || (x < minx) || (x >= maxx) || (y >= maxy)
                    || (e < miny) || (e < y);
        cb  = (y < miny) ? miny : y;
        ce  = (e > maxy - 13'sd1) ? maxy - 13'sd1 : e;
        cel = (ce >= L_S) ? L_S - 13'sd1 : ce;

        rot   = x[2:0] + cb[2:0];
        pat2  = {i_fill_pattern, i_fill_pattern} >> rot;
        pmask = 8'd1 << x[2:0];

        o_job         = '0;
        o_job.kind    = JOB_NONE;
        o_job.m_mid   = 8'hff;
        case (t_cmd'(i_command))
            CMD_ROW: begin
                o_job.oor     = !row_empty && ((re >= W_S) || (y >= L_S));
                o_job.kind    = (!row_empty && (rb < W_S) && (y < L_S)) ? JOB_WRITE
                                                                        : JOB_NONE;
                o_job.addr    = AW'(int'(y[9:0]) * ROW_BYTES + int'(rb[12:3]));
                o_job.cnt     = CW'(rel[12:3] - rb[12:3] + 10'd1);
                o_job.pat     = y[0] ? {i_fill_pattern[0], i_fill_pattern[7:1]}
                                     : i_fill_pattern;
                o_job.m_first = 8'hff << rb[2:0];
                o_job.m_last  = 8'hff >> (3'd7 - rel[2:0]);
            end
            CMD_COL: begin
                o_job.oor     = !col_empty && ((ce >= L_S) || (x >= W_S));
                o_job.kind    = (!col_empty && (x < W_S) && (cb < L_S)) ? JOB_WRITE
                                                                        : JOB_NONE;
                o_job.addr    = AW'(int'(cb[9:0]) * ROW_BYTES + int'(x[12:3]));
                o_job.cnt     = CW'(cel[9:0] - cb[9:0] + 10'd1);
                o_job.col     = 1'b1;
                o_job.bitwise = 1'b1;
                o_job.pat     = pat2[7:0];
                o_job.m_first = pmask;
                o_job.m_mid   = pmask;
                o_job.m_last  = pmask;
            end
            CMD_PIX: begin
                o_job.oor     = (x < 13'sd0) || (y < 13'sd0) || (x >= W_S) || (y >= L_S);
                o_job.kind    = o_job.oor ? JOB_NONE : JOB_WRITE;
                o_job.addr    = AW'(int'(y[9:0]) * ROW_BYTES + int'(x[12:3]));
                o_job.cnt     = CW'(1);
                o_job.bitwise = 1'b1;
                o_job.pat     = ((i_fill_pattern[5:0] & COLOUR_MASK) != 6'd0) ? 8'hff
                                                                              : 8'h00;
                o_job.m_first = pmask;
                o_job.m_mid   = pmask;
                o_job.m_last  = pmask;
            end
            CMD_READ: begin
                o_job.oor  = (int'(i_read_address) >= STORE);
                o_job.kind = o_job.oor ? JOB_NONE : JOB_READ;
                o_job.addr = AW'(i_read_address);
                o_job.cnt  = CW'(1);
            end
            default: ;
        endcase
    end

endmodule

// ===== src/dsf_queue.sv =====
// Two-entry job queue between the front end and the fill engine.
module dsf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dsf_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output dsf_pkg::t_job o_job
);
    import dsf_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

// ===== src/dsf_back.sv =====
// Fill engine: frame memory, clearing pass, read-modify-write of jobs, result register.
module dsf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  dsf_pkg::t_job i_job,
    output logic          o_job_pop,
    output logic          o_clearing,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [7:0]    o_read_data,
    output logic          o_out_of_range
);
    import dsf_pkg::*;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_RD, S_WR} t_state;

    t_state        r_state;
    logic [7:0]    r_mem [STORE];
    logic [7:0]    r_rdata;
    logic [AW-1:0] r_addr;
    logic [CW-1:0] r_cnt;
    t_kind         r_kind;
    logic          r_col, r_bitw, r_first, r_oor, r_out_valid;
    logic [7:0]    r_pat, r_mf, r_mm, r_ml;
    logic [7:0]    mask, wdat, merged;
    logic          mem_we;

    always_comb begin
        mask   = (r_first ? r_mf : r_mm) & ((r_cnt == CW'(1)) ? r_ml : 8'hff);
        wdat   = r_bitw ? {8{r_pat[0]}} : r_pat;
        merged = (r_rdata & ~mask) | (wdat & mask);
        mem_we = (r_state == S_CLEAR) || ((r_state == S_WR) && (r_kind == JOB_WRITE));
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= (r_state == S_CLEAR) ? 8'h00 : merged;
        end
        r_rdata <= r_mem[r_addr];
    end

    assign o_job_pop      = (r_state == S_IDLE) && i_job_valid && !r_out_valid;
    assign o_clearing     = (r_state == S_CLEAR);
    assign o_empty        = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + AW'(1);
                    if (r_addr == AW'(STORE - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_job_pop) begin
                        r_addr  <= i_job.addr;
                        r_cnt   <= i_job.cnt;
                        r_kind  <= i_job.kind;
                        r_col   <= i_job.col;
                        r_bitw  <= i_job.bitwise;
                        r_pat   <= i_job.pat;
                        r_mf    <= i_job.m_first;
                        r_mm    <= i_job.m_mid;
                        r_ml    <= i_job.m_last;
                        r_oor   <= i_job.oor;
                        r_first <= 1'b1;
                        if (i_job.kind == JOB_NONE) begin
                            r_out_valid    <= 1'b1;
                            o_read_data    <= 8'h00;
                            o_out_of_range <= i_job.oor;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (r_kind == JOB_READ) begin
                        r_out_valid    <= 1'b1;
                        o_read_data    <= r_rdata;
                        o_out_of_range <= 1'b0;
                        r_state        <= S_IDLE;
                    end else begin
                        r_addr  <= r_addr + (r_col ? AW'(ROW_BYTES) : AW'(1));
                        r_cnt   <= r_cnt - CW'(1);
                        r_first <= 1'b0;
                        if (r_col) begin
                            r_pat <= {r_pat[0], r_pat[7:1]};
                        end
                        if (r_cnt == CW'(1)) begin
                            r_out_valid    <= 1'b1;
                            o_read_data    <= 8'h00;
                            o_out_of_range <= r_oor;
                            r_state        <= S_IDLE;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== src/dithered_span_fill_framebuffer.sv =====
// Top level of the 1-bit-per-pixel dithered span fill framebuffer.
// Requests enter on a queue-style port: a request is taken when push is high
// and full is low. Each request is a row span, a column span, a pixel set or
// a byte read, and it produces exactly one result in request order.
// Results leave on a queue-style port: the oldest result is shown while empty
// is low and is taken when pop is high.
// The clip box is set through the write port i_cfg_we, i_cfg_idx and
// i_cfg_data, and it should be changed only while the block is idle.
// The fill engine takes a job from the queue in its idle state and then does
// a read and a write of the frame memory per touched byte. A row span touches
// at most ROW_BYTES bytes, a column span one byte per row and a pixel set one
// byte; a byte read only reads its byte, and a request that writes nothing
// gives its result straight from the idle state. The engine takes the next
// job only once the result register has emptied.
// After reset the frame memory is cleared one byte per cycle, all
// ROW_BYTES * LINES (3360) bytes, and full stays high during that time.
// When the receiver stalls, the result is held, the engine stops after its
// current request, and up to two more requests wait in the job queue.
module dithered_span_fill_framebuffer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_command,
    input  logic [11:0] i_pos_x,
    input  logic [11:0] i_pos_y,
    input  logic [11:0] i_span_end,
    input  logic [7:0]  i_fill_pattern,
    input  logic [11:0] i_read_address,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_read_data,
    output logic        o_out_of_range
);
    import dsf_pkg::*;

    t_job f_job, q_job;
    logic q_full, q_valid, q_pop, clearing;

    dsf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_span_end     (i_span_end),
        .i_fill_pattern (i_fill_pattern),
        .i_read_address (i_read_address),
        .o_job          (f_job)
    );

    assign full = q_full || clearing;

    dsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && !full),
        .i_job   (f_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    dsf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (q_valid),
        .i_job          (q_job),
        .o_job_pop      (q_pop),
        .o_clearing     (clearing),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_read_data    (o_read_data),
        .o_out_of_range (o_out_of_range)
    );

endmodule

// ===== src/dsf_checker.sv =====
// Port-level checks for the span fill framebuffer, bound to the top level.
module dsf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_read_data,
    input logic       o_out_of_range
);

    a_full_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> full)
        else $error("Request port is open right after reset.");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("A result is shown right after reset.");

    a_oor_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_of_range) |-> (o_read_data == 8'h00))
        else $error("An out-of-range result carries nonzero data.");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_read_data)))
        else $error("A stalled result changed or vanished.");

endmodule

bind dithered_span_fill_framebuffer dsf_checker u_dsf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_read_data    (o_read_data),
    .o_out_of_range (o_out_of_range)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the dithered span fill framebuffer.
`timescale 1ns / 100ps

class fill_scoreboard;
    logic [7:0] frame_mem [dsf_pkg::STORE];
    int clip_x0, clip_x1, clip_y0, clip_y1;
    logic [8:0] pending_q [$];
    int n_errors;
    int n_checked;

    function void clear_state();
        for (int i = 0; i < dsf_pkg::STORE; i++) frame_mem[i] = 8'h00;
        clip_x0 = 0;
        clip_x1 = 160;
        clip_y0 = 0;
        clip_y1 = 168;
        n_errors = 0;
        n_checked = 0;
    endfunction

    function void set_clip(dsf_pkg::t_cfg idx, logic [7:0] val);
        case (idx)
            dsf_pkg::CFG_MIN_X: clip_x0 = val;
            dsf_pkg::CFG_MAX_X: clip_x1 = val;
            dsf_pkg::CFG_MIN_Y: clip_y0 = val;
            default: clip_y1 = val;
        endcase
    endfunction

    function bit plot(int x, int y, bit val);
        int a;
        if (x < 0 || y < 0 || x >= dsf_pkg::WIDTH_PX || y >= dsf_pkg::LINES) return 1'b1;
        a = y * dsf_pkg::ROW_BYTES + x / 8;
        frame_mem[a][x % 8] = val;
        return 1'b0;
    endfunction

    function int clamp_to(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void note_request(dsf_pkg::t_cmd cmd, logic signed [11:0] px,
                               logic signed [11:0] py, logic signed [11:0] pe,
                               logic [7:0] pat, logic [11:0] addr);
        bit oor;
        logic [7:0] data;
        logic [7:0] rp;
        int b, e;
        oor = 1'b0;
        data = 8'h00;
        rp = pat;
        case (cmd)
            dsf_pkg::CMD_ROW: begin
                if (clip_x1 > clip_x0 && clip_y1 > clip_y0 && py >= clip_y0 && py < clip_y1
                        && pe >= clip_x0 && px < clip_x1 && pe >= px) begin
                    b = clamp_to(px, clip_x0, clip_x1 - 1);
                    e = clamp_to(pe, clip_x0, clip_x1 - 1);
                    if (py[0]) rp = {pat[0], pat[7:1]};
                    for (int i = b; i <= e; i++) oor |= plot(i, py, rp[i % 8]);
                end
            end
            dsf_pkg::CMD_COL: begin
                if (clip_x1 > clip_x0 && clip_y1 > clip_y0 && px >= clip_x0 && px < clip_x1
                        && py < clip_y1 && pe >= clip_y0 && pe >= py) begin
                    b = clamp_to(py, clip_y0, clip_y1 - 1);
                    e = clamp_to(pe, clip_y0, clip_y1 - 1);
                    for (int y = b; y <= e; y++) oor |= plot(px, y, pat[(px + y) % 8]);
                end
            end
            dsf_pkg::CMD_PIX: oor = plot(px, py, (pat[5:0] & dsf_pkg::COLOUR_MASK) != 0);
            default: begin
                if (addr >= dsf_pkg::STORE) oor = 1'b1;
                else data = frame_mem[addr];
            end
        endcase
        pending_q.push_back({data, oor});
    endfunction

    function void check_result(logic [7:0] data, logic oor);
        logic [8:0] exp_r;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected result data=%h oor=%b", $time, data, oor);
            n_errors++;
            return;
        end
        exp_r = pending_q.pop_front();
        n_checked++;
        if (data !== exp_r[8:1]) begin
            $display("%0t: read_data expected %h actual %h", $time, exp_r[8:1], data);
            n_errors++;
        end
        if (oor !== exp_r[0]) begin
            $display("%0t: out_of_range expected %b actual %b", $time, exp_r[0], oor);
            n_errors++;
        end
    endfunction
endclass

module tb_top;
    import dsf_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_command = '0;
    logic [11:0] i_pos_x = '0;
    logic [11:0] i_pos_y = '0;
    logic [11:0] i_span_end = '0;
    logic [7:0]  i_fill_pattern = '0;
    logic [11:0] i_read_address = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_read_data;
    logic        o_out_of_range;

    fill_scoreboard sb;
    int  cycle_count = 0;
    bit  calm_phase = 1'b0;
    bit  hold_results = 1'b0;
    int  n_requests = 0;

    dithered_span_fill_framebuffer DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Result side: checks every accepted result and stalls in random bursts or while hold_results is set.
    initial begin : result_side
        int gap;
        sb = new();
        sb.clear_state();
        forever begin
            @(posedge i_clk);
            if (pop && !empty && i_rst_n) sb.check_result(o_read_data, o_out_of_range);
            if (hold_results || (!calm_phase && $urandom_range(0, 5) == 0)) begin
                pop <= 1'b0;
                gap = hold_results ? 1 : $urandom_range(1, 7);
                repeat (gap - 1) begin
                    @(posedge i_clk);
                end
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic send_request(t_cmd cmd, logic [11:0] px, logic [11:0] py,
                                logic [11:0] pe, logic [7:0] pat, logic [11:0] addr);
        i_cfg_we <= 1'b0;
        if (!calm_phase && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_command <= cmd;
        i_pos_x <= px;
        i_pos_y <= py;
        i_span_end <= pe;
        i_fill_pattern <= pat;
        i_read_address <= addr;
        do @(posedge i_clk); while (full);
        sb.note_request(cmd, px, py, pe, pat, addr);
        n_requests++;
    endtask

    task automatic write_clip(t_cfg idx, logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_clip(idx, val);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic logic [11:0] pick_coord(int hi);
        case ($urandom_range(0, 9))
            0: return 12'($urandom);
            1: return 12'(-$urandom_range(1, 8));
            2: return 12'(hi + $urandom_range(0, 8));
            default: return 12'($urandom_range(0, hi - 1));
        endcase
    endfunction

    task automatic random_request();
        t_cmd cmd;
        logic [11:0] px, py, pe, addr;
        cmd = t_cmd'($urandom_range(0, 3));
        px = pick_coord(WIDTH_PX);
        py = pick_coord(LINES);
        if (cmd == CMD_ROW) pe = ($urandom_range(0, 7) == 0) ? pick_coord(WIDTH_PX)
                                 : 12'(px + $urandom_range(0, 40));
        else pe = ($urandom_range(0, 7) == 0) ? pick_coord(LINES)
                  : 12'(py + $urandom_range(0, 40));
        addr = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, STORE - 1));
        send_request(cmd, px, py, pe, 8'($urandom), addr);
    endtask

    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Directed part: field extremes, every command, clipping corner cases.
        send_request(CMD_ROW, 12'd0, 12'd0, 12'd159, 8'hA5, 12'd0);
        send_request(CMD_ROW, 12'h800, 12'd1, 12'h7FF, 8'h3C, 12'd0);
        send_request(CMD_ROW, 12'd50, 12'd2, 12'd40, 8'hFF, 12'd0);
        send_request(CMD_ROW, 12'd200, 12'd3, 12'd300, 8'hFF, 12'd0);
        send_request(CMD_COL, 12'd7, 12'h800, 12'h7FF, 8'h81, 12'd0);
        send_request(CMD_COL, 12'd9, 12'd20, 12'd10, 8'hFF, 12'd0);
        send_request(CMD_COL, 12'hFFF, 12'd0, 12'd5, 8'hFF, 12'd0);
        send_request(CMD_PIX, 12'd159, 12'd167, 12'd0, 8'hC0, 12'd0);
        send_request(CMD_PIX, 12'd3, 12'd5, 12'd0, 8'h01, 12'd0);
        send_request(CMD_PIX, 12'd160, 12'd0, 12'd0, 8'hFF, 12'd0);
        send_request(CMD_PIX, 12'd0, 12'hFFF, 12'd0, 8'hFF, 12'd0);
        send_request(CMD_READ, 12'd0, 12'd0, 12'd0, 8'd0, 12'd0);
        send_request(CMD_READ, 12'd0, 12'd0, 12'd0, 8'd0, 12'd20);
        send_request(CMD_READ, 12'd0, 12'd0, 12'd0, 8'd0, 12'd3359);
        send_request(CMD_READ, 12'd0, 12'd0, 12'd0, 8'd0, 12'd3360);
        send_request(CMD_READ, 12'd0, 12'd0, 12'd0, 8'd0, 12'hFFF);
        drain();
        // Clip box reaching past the framebuffer, then an empty one.
        write_clip(CFG_MAX_X, 8'd255);
        write_clip(CFG_MAX_Y, 8'd255);
        send_request(CMD_ROW, 12'd150, 12'd10, 12'd400, 8'hF0, 12'd0);
        send_request(CMD_COL, 12'd20, 12'd160, 12'd400, 8'h0F, 12'd0);
        drain();
        write_clip(CFG_MIN_X, 8'd40);
        write_clip(CFG_MAX_X, 8'd40);
        send_request(CMD_ROW, 12'd0, 12'd10, 12'd100, 8'hFF, 12'd0);
        drain();
        // Random phases, each with its own clip box.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_clip(CFG_MIN_X, 8'd0);   write_clip(CFG_MAX_X, 8'd160);
                    write_clip(CFG_MIN_Y, 8'd0);   write_clip(CFG_MAX_Y, 8'd168);
                end
                1: begin
                    write_clip(CFG_MIN_X, 8'd17);  write_clip(CFG_MAX_X, 8'd91);
                    write_clip(CFG_MIN_Y, 8'd33);  write_clip(CFG_MAX_Y, 8'd120);
                end
                2: begin
                    write_clip(CFG_MIN_X, 8'd0);   write_clip(CFG_MAX_X, 8'd255);
                    write_clip(CFG_MIN_Y, 8'd0);   write_clip(CFG_MAX_Y, 8'd255);
                end
                3: begin
                    write_clip(CFG_MIN_X, 8'd255); write_clip(CFG_MAX_X, 8'd0);
                    write_clip(CFG_MIN_Y, 8'd168); write_clip(CFG_MAX_Y, 8'd168);
                end
                default: begin
                    write_clip(CFG_MIN_X, 8'($urandom_range(0, 80)));
                    write_clip(CFG_MAX_X, 8'($urandom_range(60, 200)));
                    write_clip(CFG_MIN_Y, 8'($urandom_range(0, 80)));
                    write_clip(CFG_MAX_Y, 8'($urandom_range(60, 200)));
                end
            endcase
            if (phase == 1) begin
                hold_results = 1'b1;
                fork
                    begin
                        repeat (300) @(posedge i_clk);
                        hold_results = 1'b0;
                    end
                join_none
            end
            if (phase == 5) calm_phase = 1'b1;
            repeat (130) random_request();
            drain();
        end
        $display("tb_top: %0d requests sent, %0d results checked over six clip settings",
                 n_requests, sb.n_checked);
        if (sb.n_errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
src/dsf_pkg.sv
src/dsf_front.sv
src/dsf_queue.sv
src/dsf_back.sv
src/dithered_span_fill_framebuffer.sv
src/dsf_checker.sv
sim/tb_top.sv
